### hdl/eight_direction_gradient_magnitude_defines.svh
`ifndef EIGHT_DIRECTION_GRADIENT_MAGNITUDE_DEFINES_SVH
`define EIGHT_DIRECTION_GRADIENT_MAGNITUDE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define EGM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("egm check failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define EGM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("egm check failed");

`endif

### hdl/egm_pkg.sv
package egm_pkg;

	localparam int EGM_MAX_WIDTH   = 2048;
	localparam int EGM_MAX_HEIGHT  = 4096;
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	localparam int CFG_DATA_W = 13;
	localparam int PIX_W      = 8;
	localparam int RESP_W     = 13;

	typedef enum logic {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_index_t;

	typedef logic [PIX_W-1:0] pix_t;
	// neighbourhood, entry row*3+col
	typedef logic [8:0][PIX_W-1:0] nb_t;
	typedef logic signed [RESP_W-1:0] resp_t;

	// how the neighbourhood of one result is built from the window
	typedef struct packed {
		logic row_end;     // right edge of the previous row, from the unshifted window
		logic frame_done;  // last result of the frame
		logic top_refl;    // centre row is the first row
		logic bot_refl;    // centre row is the last row
		logic left_refl;   // centre column is the first column
	} emit_ctrl_t;

	typedef struct packed {
		logic row_end;
		logic frame_end;
	} res_flags_t;

	// 0, 45, 90 and 135 degree kernels; the other four are their negations
	localparam int KERNEL [4][9] = '{
		'{ -3,   0,  3, -10, 0, 10,  -3,  0,   3},
		'{  0,   3, 10,  -3, 0,  3, -10, -3,   0},
		'{ -3, -10, -3,   0, 0,  0,   3, 10,   3},
		'{ 10,   3,  0,   3, 0, -3,   0, -3, -10}
	};

	function automatic resp_t kernel_resp(input int k, input nb_t nb);
		logic signed [RESP_W+1:0] acc;
		acc = '0;
		for (int i = 0; i < 9; i++) begin
			acc = acc + (RESP_W+2)'(KERNEL[k][i]) * $signed({6'b0, nb[i]});
		end
		return RESP_W'(acc);
	endfunction

	function automatic logic [RESP_W-2:0] abs_resp(input resp_t r);
		return (r < 0) ? (RESP_W-1)'(-r) : (RESP_W-1)'(r);
	endfunction

endpackage

### hdl/egm_line_mem.sv
module egm_line_mem import egm_pkg::*; #(
	parameter int DEPTH = EGM_MAX_WIDTH,
	parameter int AW    = $clog2(EGM_MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [2*PIX_W-1:0]   rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [2*PIX_W-1:0]   wr_data
);

	// {older row, newer row} per column
	logic [2*PIX_W-1:0] mem [DEPTH];
	logic [2*PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// write-to-read bypass when the same column is written on the read edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/egm_window.sv
module egm_window import egm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic       shift,
	input  emit_ctrl_t ctrl,
	input  pix_t       col_top,
	input  pix_t       col_mid,
	input  pix_t       col_bot,
	output nb_t        nb
);

	// [row][col]
	logic [2:0][2:0][PIX_W-1:0] win_q;
	logic [2:0][2:0][PIX_W-1:0] shifted;
	logic [2:0][2:0][PIX_W-1:0] colsel;
	logic [2:0][PIX_W-1:0]      col_new;
	logic [1:0]                 rsel [3];

	assign col_new = {col_bot, col_mid, col_top};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			shifted[r][0] = win_q[r][1];
			shifted[r][1] = win_q[r][2];
			shifted[r][2] = col_new[r];
		end
	end

	// column choice: right edge reflects from the old window, centre from the new one
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (ctrl.row_end) begin
				colsel[r][0] = win_q[r][1];
				colsel[r][1] = win_q[r][2];
				colsel[r][2] = win_q[r][1];
			end else begin
				colsel[r][0] = ctrl.left_refl ? shifted[r][2] : shifted[r][0];
				colsel[r][1] = shifted[r][1];
				colsel[r][2] = shifted[r][2];
			end
		end
	end

	// row choice, reflect-101 at top and bottom
	always_comb begin
		rsel[0] = ctrl.top_refl ? 2'd2 : 2'd0;
		rsel[1] = 2'd1;
		rsel[2] = ctrl.bot_refl ? 2'd0 : 2'd2;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				nb[i*3+j] = colsel[rsel[i]][j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (clear) begin
			win_q <= '0;
		end else if (shift) begin
			win_q <= ctrl.frame_done ? '0 : shifted;
		end
	end

endmodule

### hdl/egm_grad.sv
`include "eight_direction_gradient_magnitude_defines.svh"

module egm_grad import egm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take_valid,
	output logic        take_ready,
	input  nb_t         nb,
	input  res_flags_t  flags,
	output logic        out_valid,
	input  logic        out_stall,
	output resp_t       grad_horizontal,
	output resp_t       grad_vertical,
	output logic [12:0] magnitude,
	output logic        row_end,
	output logic        frame_end
);

	logic                   v_s2;
	nb_t                    nb_s2;
	res_flags_t             flags_s2;
	logic                   v_s3;
	resp_t                  g_s3 [4];
	res_flags_t             flags_s3;
	logic                   out_valid_q;
	resp_t                  gx_q;
	resp_t                  gy_q;
	logic [12:0]            mag_q;
	res_flags_t             flags_q;
	logic                   go_out;
	logic                   adv3;
	logic                   adv2;
	logic [13:0]            abs_sum;
	logic [12:0]            chk_floor;

	assign go_out     = !out_valid_q || !out_stall;
	assign adv3       = !v_s3 || go_out;
	assign adv2       = !v_s2 || adv3;
	assign take_ready = adv2;

	// opposite kernels give equal magnitudes, so sum/4 of eight is sum/2 of four
	assign abs_sum = 14'(abs_resp(g_s3[0])) + 14'(abs_resp(g_s3[1]))
		+ 14'(abs_resp(g_s3[2])) + 14'(abs_resp(g_s3[3]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv2) begin
				v_s2 <= take_valid;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (go_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && take_valid) begin
			nb_s2    <= nb;
			flags_s2 <= flags;
		end
		if (adv3 && v_s2) begin
			for (int k = 0; k < 4; k++) begin
				g_s3[k] <= kernel_resp(k, nb_s2);
			end
			flags_s3 <= flags_s2;
		end
		if (go_out && v_s3) begin
			gx_q    <= g_s3[0];
			gy_q    <= g_s3[2];
			mag_q   <= abs_sum[13:1];
			flags_q <= flags_s3;
		end
	end

	assign out_valid       = out_valid_q;
	assign grad_horizontal = gx_q;
	assign grad_vertical   = gy_q;
	assign magnitude       = mag_q;
	assign row_end         = flags_q.row_end;
	assign frame_end       = flags_q.frame_end;

	assign chk_floor = 13'((14'(abs_resp(gx_q)) + 14'(abs_resp(gy_q))) >> 1);

	`EGM_ASSERT_IMP(a_frame_end_on_row_end, out_valid_q && flags_q.frame_end, flags_q.row_end)
	`EGM_ASSERT_IMP(a_mag_floor, out_valid_q, mag_q >= chk_floor)

endmodule

### hdl/eight_direction_gradient_magnitude.sv
// eight-direction gradient magnitude over a 3x3 window, one grayscale pixel per transfer
// input channel: pixel/flush with in_valid/in_stall; raster order, frame after frame.
//   after the last row of a frame, send width+1 items with flush set to drain it;
//   a flush item outside the drain, or a pixel item during it, is taken and dropped
// output channel: gradients, magnitude and row/frame marks with out_valid/out_stall;
//   a result belongs to the pixel one row and one column before the current input
// configuration: cfg_index/cfg_data with cfg_valid/cfg_ready (always ready); index 0 is
//   the frame width, index 1 the frame height; any write restarts the frame and must
//   only be made while the block is idle
// throughput: one item per clock while the output is not stalled, set by the single
//   read-modify-write of the line store column per item (read on acceptance, written
//   back as the item leaves stage 1)
// reset: 640 x 480, frame position and window cleared; line stores are not cleared,
//   their stale columns only fall in reflected positions
// stall: the output register holds its result; the pipeline behind it keeps taking
//   items until it is full, then raises in_stall
`include "eight_direction_gradient_magnitude_defines.svh"

module eight_direction_gradient_magnitude import egm_pkg::*; #(
	parameter int MAX_WIDTH  = EGM_MAX_WIDTH,
	parameter int MAX_HEIGHT = EGM_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel,
	input  logic                  flush,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [12:0]    grad_horizontal,
	output logic signed [12:0]    grad_vertical,
	output logic [12:0]           magnitude,
	output logic                  row_end,
	output logic                  frame_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);        // column address
	localparam int WW = $clog2(MAX_WIDTH + 1);    // width value
	localparam int HW = $clog2(MAX_HEIGHT + 1);   // height value
	localparam int YW = $clog2(MAX_HEIGHT + 2);   // row count runs one past the height
	localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
	localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

	// frame position and sizes
	logic [WW-1:0]      w_eff_q;
	logic [HW-1:0]      h_eff_q;
	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q;
	logic               draining_q;

	// stage 1: line store read data arrives, window shifts
	logic               v_s1;
	emit_ctrl_t         ctrl_s1;
	logic               emit_s1;
	logic [XW-1:0]      addr_s1;
	pix_t               p_s1;

	logic               in_acc;
	logic               work;
	logic               in_ready;
	logic               lv1;
	logic               grad_ready;
	logic [YW-1:0]      h_y;
	logic [WW-1:0]      x_inc;
	logic [YW-1:0]      y_inc;
	logic               wrap;
	logic               row_end_s0;
	logic               center_s0;
	emit_ctrl_t         ctrl_s0;
	pix_t               p_s0;
	logic [2*PIX_W-1:0] rd_data;
	nb_t                nb;
	res_flags_t         flags_s1;
	cfg_index_t         cfg_sel;
	logic [WW-1:0]      w_new;
	logic [HW-1:0]      h_new;

	assign cfg_ready = 1'b1;
	assign cfg_sel   = cfg_index_t'(cfg_index);

	// out-of-range sizes clamp to [2, max]
	always_comb begin
		if (cfg_data[11:0] < 12'd2) begin
			w_new = WW'(2);
		end else if (32'(cfg_data[11:0]) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(cfg_data[11:0]);
		end
		if (cfg_data < 13'd2) begin
			h_new = HW'(2);
		end else if (32'(cfg_data) > MAX_HEIGHT) begin
			h_new = HW'(MAX_HEIGHT);
		end else begin
			h_new = HW'(cfg_data);
		end
	end

	// handshake; items whose flush disagrees with the drain state are taken and dropped
	assign in_acc   = in_valid && !in_stall;
	assign work     = in_acc && (flush == draining_q);
	assign lv1      = v_s1 && (!emit_s1 || grad_ready);
	assign in_ready = !v_s1 || lv1;
	assign in_stall = !in_ready;

	// position decode for the accepted item
	assign h_y   = YW'(h_eff_q);
	assign x_inc = WW'(x_q) + WW'(1);
	assign y_inc = y_q + YW'(1);
	assign wrap  = x_inc >= w_eff_q;
	assign p_s0  = draining_q ? '0 : pixel;

	always_comb begin
		row_end_s0         = (x_q == '0) && (y_q >= YW'(2));
		center_s0          = (x_q != '0) && (y_q != '0);
		ctrl_s0.row_end    = row_end_s0;
		ctrl_s0.frame_done = row_end_s0 && (y_q > h_y);
		ctrl_s0.top_refl   = row_end_s0 ? (y_q == YW'(2)) : (y_q == YW'(1));
		ctrl_s0.bot_refl   = row_end_s0 ? (y_q > h_y) : (y_q >= h_y);
		ctrl_s0.left_refl  = (x_q == XW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q    <= WW'(W_RST);
			h_eff_q    <= HW'(H_RST);
			x_q        <= '0;
			y_q        <= '0;
			draining_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_sel)
				CFG_FRAME_WIDTH:  w_eff_q <= w_new;
				CFG_FRAME_HEIGHT: h_eff_q <= h_new;
				default:          w_eff_q <= w_eff_q;
			endcase
			x_q        <= '0;
			y_q        <= '0;
			draining_q <= 1'b0;
		end else if (work) begin
			priority if (ctrl_s0.frame_done) begin
				// frame drained, wait for the next frame's first pixel
				x_q        <= '0;
				y_q        <= '0;
				draining_q <= 1'b0;
			end else if (wrap) begin
				x_q <= '0;
				y_q <= y_inc;
				if (!draining_q && y_inc >= h_y) begin
					draining_q <= 1'b1;
				end
			end else begin
				x_q <= XW'(x_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= work;
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			ctrl_s1 <= ctrl_s0;
			emit_s1 <= row_end_s0 || center_s0;
			addr_s1 <= x_q;
			p_s1    <= p_s0;
		end
	end

	// column store: older row moves up, newer row takes the incoming pixel
	egm_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (XW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (work),
		.rd_addr (x_q),
		.rd_data (rd_data),
		.wr_en   (lv1),
		.wr_addr (addr_s1),
		.wr_data ({rd_data[PIX_W-1:0], p_s1})
	);

	egm_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cfg_valid),
		.shift   (lv1),
		.ctrl    (ctrl_s1),
		.col_top (rd_data[2*PIX_W-1:PIX_W]),
		.col_mid (rd_data[PIX_W-1:0]),
		.col_bot (p_s1),
		.nb      (nb)
	);

	assign flags_s1.row_end   = ctrl_s1.row_end;
	assign flags_s1.frame_end = ctrl_s1.frame_done;

	egm_grad u_grad (
		.clk             (clk),
		.arst_n          (arst_n),
		.take_valid      (lv1 && emit_s1),
		.take_ready      (grad_ready),
		.nb              (nb),
		.flags           (flags_s1),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.grad_horizontal (grad_horizontal),
		.grad_vertical   (grad_vertical),
		.magnitude       (magnitude),
		.row_end         (row_end),
		.frame_end       (frame_end)
	);

	`EGM_ASSERT_IMP(a_drain_past_last_row, draining_q, y_q >= h_y)
	`EGM_ASSERT_NXT(a_restart_after_frame, work && ctrl_s0.frame_done, x_q == '0 && y_q == '0 && !draining_q)

endmodule

### tb/sv/tb_eight_direction_gradient_magnitude.sv
`timescale 1ns / 100ps

module tb_eight_direction_gradient_magnitude;
	import egm_pkg::*;

	localparam int CLK_HALF      = 5;
	// watchdog limit on the whole run, in cycles
	localparam int CYCLE_LIMIT   = 100000;
	// settle time once no result is expected, dropped items may still be in flight
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 240;
	localparam int WIDE_PIXELS   = 100;
	localparam int TALL_PIXELS   = 120;
	localparam int LONG_HOLD     = 300;
	localparam int MAX_PRINTED   = 40;

	// 0, 45, 90, 135, 180, 225, 270 and 315 degrees, entry row*3+col, no flip
	localparam int DIRECTION_KERNEL [8][9] = '{
		'{ -3,   0,   3, -10, 0,  10,  -3,   0,   3},
		'{  0,   3,  10,  -3, 0,   3, -10,  -3,   0},
		'{ -3, -10,  -3,   0, 0,   0,   3,  10,   3},
		'{ 10,   3,   0,   3, 0,  -3,   0,  -3, -10},
		'{  3,   0,  -3,  10, 0, -10,   3,   0,  -3},
		'{  0,  -3, -10,   3, 0,  -3,  10,   3,   0},
		'{  3,  10,   3,   0, 0,   0,  -3, -10,  -3},
		'{-10,  -3,   0,  -3, 0,   3,   0,   3,  10}
	};

	typedef struct packed {
		resp_t       horizontal;
		resp_t       vertical;
		logic [12:0] magnitude;
		logic        row_end;
		logic        frame_end;
	} gradient_result_t;

	// every input known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	pix_t                  pixel     = '0;
	logic                  flush     = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	resp_t                 grad_horizontal;
	resp_t                 grad_vertical;
	logic [12:0]           magnitude;
	logic                  row_end;
	logic                  frame_end;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index = CFG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor state: registers, line stores, window and raster position
	logic [11:0]           model_width;
	logic [12:0]           model_height;
	pix_t                  older_row [EGM_MAX_WIDTH];
	pix_t                  newer_row [EGM_MAX_WIDTH];
	pix_t                  window [9];
	int unsigned           column;
	int unsigned           row;
	bit                    in_drain;

	gradient_result_t      pending_gradients [$];
	int                    mismatches    = 0;
	int unsigned           cycle_count   = 0;
	int                    counted_items = 0;
	// steady: neither side idles; hold_request: one long receiver hold-off, in cycles
	bit                    steady        = 1'b0;
	int                    hold_request  = 0;

	eight_direction_gradient_magnitude uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pixel           (pixel),
		.flush           (flush),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.grad_horizontal (grad_horizontal),
		.grad_vertical   (grad_vertical),
		.magnitude       (magnitude),
		.row_end         (row_end),
		.frame_end       (frame_end),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// sizes outside the legal range are clamped, not rejected
	function automatic int unsigned active_width();
		if (model_width < 2) return 2;
		if (model_width > EGM_MAX_WIDTH) return EGM_MAX_WIDTH;
		return model_width;
	endfunction

	function automatic int unsigned active_height();
		if (model_height < 2) return 2;
		if (model_height > EGM_MAX_HEIGHT) return EGM_MAX_HEIGHT;
		return model_height;
	endfunction

	// positions, drain flag and window cleared; line stores survive
	function automatic void restart_frame();
		foreach (window[i]) window[i] = '0;
		column   = 0;
		row      = 0;
		in_drain = 1'b0;
	endfunction

	function automatic void reset_gradient_model();
		model_width  = 12'(FRAME_WIDTH_RST);
		model_height = 13'(FRAME_HEIGHT_RST);
		foreach (older_row[i]) begin
			older_row[i] = '0;
			newer_row[i] = '0;
		end
		restart_frame();
	endfunction

	function automatic void set_frame_register(input cfg_index_t idx,
			input logic [CFG_DATA_W-1:0] value);
		// the width register only keeps 12 bits
		if (idx == CFG_FRAME_WIDTH) model_width = value[11:0];
		else model_height = value;
		restart_frame();
	endfunction

	// neighbourhood from window columns lc/cc/rc, rows reflected at the top and bottom
	function automatic gradient_result_t window_gradient(input int lc, input int cc,
			input int rc, input int unsigned centre_row, input int unsigned h,
			input bit last_in_row, input bit last_in_frame);
		int               taps [9];
		int               src_col [3];
		int               src_row [3];
		int               acc;
		int               total;
		gradient_result_t res;
		src_col = '{lc, cc, rc};
		src_row[0] = (centre_row == 0) ? 2 : 0;
		src_row[1] = 1;
		src_row[2] = (centre_row + 1 >= h) ? 0 : 2;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				taps[i*3 + j] = window[src_row[i]*3 + src_col[j]];
		res   = '0;
		total = 0;
		for (int k = 0; k < 8; k++) begin
			acc = 0;
			for (int i = 0; i < 9; i++) acc += DIRECTION_KERNEL[k][i] * taps[i];
			if (k == 0) res.horizontal = resp_t'(acc);
			if (k == 2) res.vertical = resp_t'(acc);
			total += (acc < 0) ? -acc : acc;
		end
		res.magnitude = 13'(total / 4);
		res.row_end   = last_in_row;
		res.frame_end = last_in_frame;
		return res;
	endfunction

	// one accepted item: zero or one expected result
	function automatic void advance_gradient_model(input pix_t pix_in, input logic flush_in);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		pix_t        p;
		pix_t        older_pix;
		pix_t        newer_pix;
		bit          frame_done;
		w = active_width();
		h = active_height();
		// stray flush outside the drain, or pixel during it: dropped
		if (flush_in != in_drain) return;
		p = in_drain ? '0 : pix_in;
		x = column;
		y = row;
		if (x >= w) x = 0;
		frame_done = 1'b0;
		// right edge of the row before, from the window as it stands
		if (x == 0 && y >= 2) begin
			frame_done = (y - 1 >= h);
			pending_gradients.push_back(window_gradient(1, 2, 1, y - 2, h, 1'b1, frame_done));
		end
		older_pix    = older_row[x];
		newer_pix    = newer_row[x];
		older_row[x] = newer_pix;
		newer_row[x] = p;
		for (int r = 0; r < 3; r++) begin
			window[r*3]     = window[r*3 + 1];
			window[r*3 + 1] = window[r*3 + 2];
		end
		window[2] = older_pix;
		window[5] = newer_pix;
		window[8] = p;
		// after the frame_end result the block waits for the next frame
		if (frame_done) begin
			restart_frame();
			return;
		end
		// one column behind; the first column reflects to the right
		if (x >= 1 && y >= 1)
			pending_gradients.push_back(window_gradient((x == 1) ? 2 : 0, 1, 2, y - 1, h,
					1'b0, 1'b0));
		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (!in_drain && y >= h) in_drain = 1'b1;
		end
		column = x;
		row    = y;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED) $display("%0t: mismatch, %s", $time, what);
	endtask

	task automatic check_result();
		gradient_result_t want;
		if (pending_gradients.size() == 0) begin
			report_mismatch("result transfer with nothing expected");
			return;
		end
		want = pending_gradients.pop_front();
		if (grad_horizontal !== want.horizontal)
			report_mismatch($sformatf("grad_horizontal %0d, expected %0d",
					grad_horizontal, want.horizontal));
		if (grad_vertical !== want.vertical)
			report_mismatch($sformatf("grad_vertical %0d, expected %0d",
					grad_vertical, want.vertical));
		if (magnitude !== want.magnitude)
			report_mismatch($sformatf("magnitude %0d, expected %0d", magnitude, want.magnitude));
		if (row_end !== want.row_end)
			report_mismatch($sformatf("row_end %b, expected %b", row_end, want.row_end));
		if (frame_end !== want.frame_end)
			report_mismatch($sformatf("frame_end %b, expected %b", frame_end, want.frame_end));
	endtask

	// everything sampled at the rising edge, before the block's own updates land;
	// a result never leaves in the cycle its input is taken, so check before predict
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) check_result();
			if (cfg_valid && cfg_ready) set_frame_register(cfg_index, cfg_data);
			if (in_valid && !in_stall) advance_gradient_model(pixel, flush);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_eight_direction_gradient_magnitude: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- receiver

	// per result a random stall; a requested hold-off comes first
	initial begin : receiver
		int gap;
		forever begin
			if (hold_request > 0) begin
				gap          = hold_request;
				hold_request = 0;
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			gap = steady ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			// wait for the transfer itself
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------- sender side

	function automatic pix_t draw_pixel();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// valid stays high into the next item unless that item draws a gap
	task automatic send_item(input pix_t pix, input logic is_flush);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= pix;
		flush    <= is_flush;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// idle means every expected result has arrived, plus time for dropped items
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_gradients.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// w*h pixels then w+1 flushes; cut_at >= 0 stops after that many pixels
	task automatic send_frame(input int w, input int h, input int cut_at, input bit noisy);
		for (int i = 0; i < w * h; i++) begin
			if (i == cut_at) return;
			// stray flush outside the drain, dropped
			if (noisy && $urandom_range(0, 19) == 0) send_item(draw_pixel(), 1'b1);
			send_item(draw_pixel(), 1'b0);
			counted_items++;
		end
		for (int i = 0; i <= w; i++) begin
			// pixel during the drain, dropped
			if (noisy && $urandom_range(0, 19) == 0) send_item(draw_pixel(), 1'b0);
			send_item(draw_pixel(), 1'b1);
			counted_items++;
		end
	endtask

	// ---------------------------------------------------------------- tests

	// sizes below the minimum act as 2 x 2; every dropped-item case on a tiny frame
	task automatic test_smallest_frame();
		write_reg(CFG_FRAME_WIDTH, 13'd1);
		write_reg(CFG_FRAME_HEIGHT, 13'd0);
		send_item(8'hA5, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h5A, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'h00, 1'b1);
		// the drain is over, so this flush is dropped too
		send_item(8'hFF, 1'b1);
		wait_drained();
	endtask

	// full-scale edges on a 3 x 3 frame, right column and bottom row at 255
	task automatic test_stripe_frame();
		write_reg(CFG_FRAME_WIDTH, 13'd3);
		write_reg(CFG_FRAME_HEIGHT, 13'd3);
		for (int y = 0; y < 3; y++)
			for (int x = 0; x < 3; x++)
				send_item((x == 2 || y == 2) ? 8'hFF : 8'h00, 1'b0);
		for (int i = 0; i < 4; i++) send_item(8'h00, 1'b1);
		wait_drained();
	endtask

	// a register write part-way through a frame starts it over
	task automatic test_restart_mid_frame();
		write_reg(CFG_FRAME_WIDTH, 13'd5);
		write_reg(CFG_FRAME_HEIGHT, 13'd4);
		send_frame(5, 4, 7, 1'b0);
		wait_drained();
		write_reg(CFG_FRAME_HEIGHT, 13'd4);
		send_frame(5, 4, -1, 1'b0);
		wait_drained();
	endtask

	// width register all ones clamps to the widest line, height 1 acts as 2;
	// only the start of the first row, so no result may appear
	task automatic test_widest_frame();
		write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
		write_reg(CFG_FRAME_HEIGHT, 13'h0001);
		send_frame(EGM_MAX_WIDTH, 2, WIDE_PIXELS, 1'b0);
		wait_drained();
	endtask

	// width 0 acts as 2, height all ones clamps to the tallest frame; run flat out
	// through the top rows, far from the bottom edge
	task automatic test_tallest_frame();
		write_reg(CFG_FRAME_WIDTH, 13'h0000);
		write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
		steady = 1'b1;
		send_frame(2, EGM_MAX_HEIGHT, TALL_PIXELS, 1'b0);
		wait_drained();
		steady = 1'b0;
	endtask

	// mostly whole frames of random size and content, some cut short, some noise;
	// the first one runs into a long receiver hold-off so the input side backs up
	task automatic test_random_frames();
		int w;
		int h;
		int cut_at;
		bit first;
		first         = 1'b1;
		counted_items = 0;
		hold_request  = LONG_HOLD;
		while (counted_items < RANDOM_ITEMS) begin
			w = first ? 24 : $urandom_range(2, 16);
			h = first ? 6 : $urandom_range(2, 8);
			// width bit 12 is not kept, so toggle it freely
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_FRAME_WIDTH, {1'($urandom_range(0, 1)), 12'(w)});
				write_reg(CFG_FRAME_HEIGHT, 13'(h));
			end else begin
				write_reg(CFG_FRAME_HEIGHT, 13'(h));
				write_reg(CFG_FRAME_WIDTH, {1'($urandom_range(0, 1)), 12'(w)});
			end
			steady = !first && ($urandom_range(0, 4) == 0);
			cut_at = (!first && $urandom_range(0, 7) == 0) ? $urandom_range(1, w * h - 1) : -1;
			send_frame(w, h, cut_at, 1'b1);
			wait_drained();
			first = 1'b0;
		end
		steady = 1'b0;
	endtask

	initial begin
		reset_gradient_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_smallest_frame();
		test_stripe_frame();
		test_restart_mid_frame();
		test_widest_frame();
		test_tallest_frame();
		test_random_frames();
		wait_drained();
		if (mismatches == 0) begin
			$display("tb_eight_direction_gradient_magnitude: PASS");
		end else begin
			$display("tb_eight_direction_gradient_magnitude: FAIL");
		end
		$finish;
	end

endmodule

### eight_direction_gradient_magnitude.f
+incdir+hdl
hdl/egm_pkg.sv
hdl/egm_line_mem.sv
hdl/egm_window.sv
hdl/egm_grad.sv
hdl/eight_direction_gradient_magnitude.sv
tb/sv/tb_eight_direction_gradient_magnitude.sv
